// ----- rtl/mwpg_pkg.sv -----
`default_nettype none
package mwpg_pkg;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [63:0] area_t;

  localparam logic [1:0] CFG_WEB_RINGS = 2'd0;
  localparam logic [1:0] CFG_CENTRE_X  = 2'd1;
  localparam logic [1:0] CFG_CENTRE_Y  = 2'd2;
  localparam logic [1:0] CFG_CENTRE_Z  = 2'd3;

  localparam int unsigned MulSteps = 12;
  localparam int unsigned DivBits  = 33;
endpackage
`default_nettype wire

// ----- rtl/meter_web_patch_generator_core.sv -----
// Channel  | Handshake                    | Payload
// in       | in_valid_i / in_stall_o      | point_x/y/z, final_point
// out      | out_valid_o / out_stall_i    | patch_x/y/z, area_x/y/z, indices, run_end
// cfg      | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
// Each edge of an item passes through the serial divider, and each patch of it through
// the shared multiplier and is loaded once the output is free; a final item that is
// not also the first point of its run adds the closing edge back to that first point.
// The block takes one item at a time and stalls its input until all patches
// of that item have been loaded into the output register.
// Reset clears the loop state, the ring count to one and the centre to zero.
`default_nettype none
module meter_web_patch_generator_core #(
  parameter int unsigned MAX_RINGS = 32,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire mwpg_pkg::coord_t point_x_i,
  input  wire mwpg_pkg::coord_t point_y_i,
  input  wire mwpg_pkg::coord_t point_z_i,
  input  wire logic            final_point_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output mwpg_pkg::coord_t     patch_x_o,
  output mwpg_pkg::coord_t     patch_y_o,
  output mwpg_pkg::coord_t     patch_z_o,
  output mwpg_pkg::area_t      area_x_o,
  output mwpg_pkg::area_t      area_y_o,
  output mwpg_pkg::area_t      area_z_o,
  output logic [9:0]           edge_index_o,
  output logic [4:0]           ring_index_o,
  output logic                 run_end_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import mwpg_pkg::*;

  localparam int unsigned EdgeLimI = (MAX_EDGES - 1 < 1023) ? MAX_EDGES - 1 : 1023;
  localparam logic [9:0] EdgeLim = 10'(EdgeLimI);
  localparam logic [5:0] MaxR = 6'(MAX_RINGS);

  typedef enum logic [2:0] {S_IDLE, S_DLOAD, S_DRUN, S_CORN, S_MUL, S_EMIT} state_e;

  state_e      state_q;
  logic [5:0]  rings_q;
  coord_t      cen_q [3];
  coord_t      first_q [3];
  coord_t      prev_q [3];
  coord_t      pnt_q [3];
  logic [9:0]  seen_q;
  coord_t      ea_q [3];
  coord_t      eb_q [3];
  logic [9:0]  edge_q;
  logic        second_q;
  logic [9:0]  second_id_q;
  logic [1:0]  div_dim_q;
  logic        div_b_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] dq_q;
  logic [5:0]  rem_q;
  logic        div_neg_q;
  logic signed [33:0] s0_q [3];
  logic signed [33:0] s1_q [3];
  coord_t      x0_q [3];
  coord_t      x1_q [3];
  coord_t      x2_q [3];
  coord_t      x3_q [3];
  logic [4:0]  ring_q;
  logic [3:0]  mul_cnt_q;
  logic signed [65:0] prod_q;
  logic [1:0]  prod_dim_q;
  logic        prod_neg_q;
  logic signed [67:0] acc_q [3];

  logic        out_valid_q;
  coord_t      px_q, py_q, pz_q;
  area_t       ax_q, ay_q, az_q;
  logic [9:0]  oedge_q;
  logic [4:0]  oring_q;
  logic        orun_q;

  logic [5:0]  r_eff;
  logic        ring_last;
  logic        in_acc;
  logic        out_free;
  logic signed [32:0] div_diff;
  logic [6:0]  trial;
  logic        trial_ge;
  logic signed [32:0] u [3];
  logic signed [32:0] v [3];
  logic signed [32:0] w [3];
  logic signed [32:0] t [3];
  logic signed [32:0] op_a, op_b;
  logic [1:0]  mdim, pd, qd;
  logic [1:0]  mj;
  logic [9:0]  seen_m1;

  function automatic coord_t mean4(coord_t a, coord_t b, coord_t c, coord_t d);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b) + 35'(c) + 35'(d) + 35'sd2;
    return coord_t'(s >>> 2);
  endfunction

  function automatic area_t half_sat(logic signed [67:0] a);
    logic signed [67:0] h;
    h = (a + 68'sd1) >>> 1;
    if (h[67:63] == 5'b00000 || h[67:63] == 5'b11111) begin
      return h[63:0];
    end
    return h[67] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic [9:0] edge_sat(logic [9:0] e);
    return (e > EdgeLim) ? EdgeLim : e;
  endfunction

  assign r_eff = (rings_q == 6'd0) ? 6'd1 : ((rings_q > MaxR) ? MaxR : rings_q);
  assign ring_last = ({1'b0, ring_q} + 6'd1) == r_eff;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign seen_m1 = seen_q - 10'd1;

  assign div_diff = 33'(cen_q[div_dim_q]) -
                    33'(div_b_q ? eb_q[div_dim_q] : ea_q[div_dim_q]);
  assign trial = {rem_q, dq_q[32]};
  assign trial_ge = trial >= {1'b0, r_eff};

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      u[d] = 33'(x2_q[d]) - 33'(x1_q[d]);
      v[d] = 33'(x0_q[d]) - 33'(x1_q[d]);
      w[d] = 33'(x0_q[d]) - 33'(x3_q[d]);
      t[d] = 33'(x2_q[d]) - 33'(x3_q[d]);
    end
    mdim = mul_cnt_q[3:2];
    mj = mul_cnt_q[1:0];
    pd = (mdim == 2'd0) ? 2'd1 : ((mdim == 2'd1) ? 2'd2 : 2'd0);
    qd = (mdim == 2'd0) ? 2'd2 : ((mdim == 2'd1) ? 2'd0 : 2'd1);
    case (mj)
      2'd0: begin op_a = u[pd]; op_b = v[qd]; end
      2'd1: begin op_a = u[qd]; op_b = v[pd]; end
      2'd2: begin op_a = w[pd]; op_b = t[qd]; end
      2'd3: begin op_a = w[qd]; op_b = t[pd]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rings_q <= 6'd1;
      for (int d = 0; d < 3; d++) begin
        cen_q[d] <= '0;
        first_q[d] <= '0;
        prev_q[d] <= '0;
      end
      seen_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WEB_RINGS: rings_q <= cfg_data_i[5:0];
          CFG_CENTRE_X:  cen_q[0] <= cfg_data_i;
          CFG_CENTRE_Y:  cen_q[1] <= cfg_data_i;
          CFG_CENTRE_Z:  cen_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_q[0] <= point_x_i;
        prev_q[1] <= point_y_i;
        prev_q[2] <= point_z_i;
        if (seen_q == 10'd0) begin
          first_q[0] <= point_x_i;
          first_q[1] <= point_y_i;
          first_q[2] <= point_z_i;
        end
        if (final_point_i) begin
          seen_q <= '0;
        end else if (seen_q != 10'd1023) begin
          seen_q <= seen_q + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      second_q <= 1'b0;
      div_cnt_q <= '0;
      mul_cnt_q <= '0;
      ring_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pnt_q[0] <= point_x_i;
            pnt_q[1] <= point_y_i;
            pnt_q[2] <= point_z_i;
            second_id_q <= edge_sat(seen_q);
            if (seen_q == 10'd0) begin
              ea_q[0] <= point_x_i;
              ea_q[1] <= point_y_i;
              ea_q[2] <= point_z_i;
              eb_q[0] <= point_x_i;
              eb_q[1] <= point_y_i;
              eb_q[2] <= point_z_i;
              edge_q <= '0;
              second_q <= 1'b0;
              div_dim_q <= 2'd0;
              div_b_q <= 1'b0;
              state_q <= final_point_i ? S_DLOAD : S_IDLE;
            end else begin
              ea_q <= prev_q;
              eb_q[0] <= point_x_i;
              eb_q[1] <= point_y_i;
              eb_q[2] <= point_z_i;
              edge_q <= edge_sat(seen_m1);
              second_q <= final_point_i;
              div_dim_q <= 2'd0;
              div_b_q <= 1'b0;
              state_q <= S_DLOAD;
            end
          end
        end
        S_DLOAD: begin
          div_neg_q <= div_diff[32];
          dq_q <= div_diff[32] ? 33'(-div_diff) : 33'(div_diff);
          rem_q <= '0;
          div_cnt_q <= '0;
          state_q <= S_DRUN;
        end
        S_DRUN: begin
          rem_q <= trial_ge ? 6'(trial - {1'b0, r_eff}) : trial[5:0];
          dq_q <= {dq_q[31:0], trial_ge};
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(DivBits - 1)) begin
            if (div_b_q) begin
              s1_q[div_dim_q] <= div_neg_q ? -34'({dq_q[31:0], trial_ge})
                                           : 34'({dq_q[31:0], trial_ge});
            end else begin
              s0_q[div_dim_q] <= div_neg_q ? -34'({dq_q[31:0], trial_ge})
                                           : 34'({dq_q[31:0], trial_ge});
            end
            if (div_b_q && div_dim_q == 2'd2) begin
              x0_q <= ea_q;
              x1_q <= eb_q;
              ring_q <= '0;
              state_q <= S_CORN;
            end else begin
              div_b_q <= !div_b_q;
              if (div_b_q) begin
                div_dim_q <= div_dim_q + 2'd1;
              end
              state_q <= S_DLOAD;
            end
          end
        end
        S_CORN: begin
          for (int d = 0; d < 3; d++) begin
            x3_q[d] <= ring_last ? cen_q[d] : coord_t'(34'(x0_q[d]) + s0_q[d]);
            x2_q[d] <= ring_last ? cen_q[d] : coord_t'(34'(x1_q[d]) + s1_q[d]);
            acc_q[d] <= '0;
          end
          mul_cnt_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (mul_cnt_q < 4'(MulSteps)) begin
            prod_q <= op_a * op_b;
            prod_dim_q <= mdim;
            prod_neg_q <= mj[0];
          end
          if (mul_cnt_q != 4'd0) begin
            acc_q[prod_dim_q] <= prod_neg_q ? acc_q[prod_dim_q] - 68'(prod_q)
                                            : acc_q[prod_dim_q] + 68'(prod_q);
          end
          if (mul_cnt_q == 4'(MulSteps)) begin
            state_q <= S_EMIT;
          end else begin
            mul_cnt_q <= mul_cnt_q + 4'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            px_q <= mean4(x0_q[0], x1_q[0], x2_q[0], x3_q[0]);
            py_q <= mean4(x0_q[1], x1_q[1], x2_q[1], x3_q[1]);
            pz_q <= mean4(x0_q[2], x1_q[2], x2_q[2], x3_q[2]);
            ax_q <= half_sat(acc_q[0]);
            ay_q <= half_sat(acc_q[1]);
            az_q <= half_sat(acc_q[2]);
            oedge_q <= edge_q;
            oring_q <= ring_q;
            orun_q <= ring_last && !second_q;
            if (!ring_last) begin
              x0_q <= x3_q;
              x1_q <= x2_q;
              ring_q <= ring_q + 5'd1;
              state_q <= S_CORN;
            end else if (second_q) begin
              second_q <= 1'b0;
              ea_q <= pnt_q;
              eb_q <= first_q;
              edge_q <= second_id_q;
              div_dim_q <= 2'd0;
              div_b_q <= 1'b0;
              state_q <= S_DLOAD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign patch_x_o = px_q;
  assign patch_y_o = py_q;
  assign patch_z_o = pz_q;
  assign area_x_o = ax_q;
  assign area_y_o = ay_q;
  assign area_z_o = az_q;
  assign edge_index_o = oedge_q;
  assign ring_index_o = oring_q;
  assign run_end_o = orun_q;

  a_ring_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORN || state_q == S_MUL || state_q == S_EMIT) |->
      {1'b0, ring_q} < r_eff)
    else $error("ring counter beyond ring count");
  a_mul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_cnt_q <= 4'(MulSteps))
    else $error("multiply step counter overrun");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && out_stall_i) |=> $stable(px_q))
    else $error("output overwritten while stalled");
endmodule
`default_nettype wire
